// ===== rtl/core/rgba_fade_ramp_generator_core_macros.svh =====
// Assertion macros shared by the fade ramp generator RTL.
`ifndef RGBA_FADE_RAMP_GENERATOR_CORE_MACROS_SVH
`define RGBA_FADE_RAMP_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RFRG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RFRG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rfrg_pkg.sv =====
// Shared constants, types and codes of the fade ramp generator.
package rfrg_pkg;

    localparam int TIME_BITS   = 16;
    localparam int FLOOR_STEPS = 4;
    localparam int COLOR_W     = 8;
    localparam int COLOR_MAX   = 255;
    localparam int NUM_LANES   = 4;
    localparam int TL_W        = TIME_BITS + 2;
    localparam int DUR_W       = 16;
    localparam int ID_W        = 16;
    localparam int SKIP_W      = 4;
    localparam int DUR_MAX     = (2 ** TIME_BITS) - 1;

    // Division datapath sizes.
    localparam int PROD_W = COLOR_W + TIME_BITS;
    localparam int REM_W  = TIME_BITS + 1;
    localparam int ACC_W  = REM_W + PROD_W;
    localparam int CNT_W  = $clog2(PROD_W);
    localparam int SUM_W  = PROD_W + 2;

    // Stream widths.
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 56;
    localparam int S_USER_W = 2;

    localparam logic signed [TL_W-1:0] FLOOR_VAL = TL_W'(-FLOOR_STEPS);

    typedef logic [COLOR_W-1:0] color_t;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_START = 2'd1,
        MODE_SET   = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    // Sequencer controls to the lanes.
    typedef struct packed {
        logic load;
        logic step;
    } lane_ctl_t;

    // Signed quotient of one lane as sign and magnitude.
    typedef struct packed {
        logic              neg;
        logic [PROD_W-1:0] mag;
    } lane_res_t;

    // Input tdata layout, lowest field last.
    typedef struct packed {
        logic [ID_W-1:0]   notify_id;
        logic              has_notify;
        logic [DUR_W-1:0]  duration;
        color_t            alpha;
        color_t            blue;
        color_t            green;
        color_t            red;
        logic [SKIP_W-1:0] frame_skip;
    } in_data_t;

    // Result tdata layout, lowest field last.
    typedef struct packed {
        logic [ID_W-1:0] notify_out;
        logic            notify_fire;
        logic            hidden;
        color_t          out_alpha;
        color_t          out_blue;
        color_t          out_green;
        color_t          out_red;
    } result_t;

    localparam int IN_W  = $bits(in_data_t);
    localparam int RES_W = $bits(result_t);

endpackage

// ===== rtl/core/rfrg_lane.sv =====
// One color channel lane: scaled difference and a bit-serial restoring divider.
module rfrg_lane (
    input  logic                          aclk,
    input  rfrg_pkg::lane_ctl_t           ctl,
    input  rfrg_pkg::color_t              from_col,
    input  rfrg_pkg::color_t              to_col,
    input  logic [rfrg_pkg::TIME_BITS-1:0] t_val,
    input  logic [rfrg_pkg::TIME_BITS-1:0] total,
    output rfrg_pkg::lane_res_t           res
);
    import rfrg_pkg::*;

    logic signed [COLOR_W:0] diff;
    logic [COLOR_W-1:0]      mag;
    logic [ACC_W-1:0]        acc_reg;
    logic [ACC_W-1:0]        acc_next;
    logic [ACC_W-1:0]        shifted;
    logic [REM_W-1:0]        rem_top;
    logic                    neg_reg;

    // Sign and magnitude of start minus target.
    always_comb begin
        diff = signed'({1'b0, from_col}) - signed'({1'b0, to_col});
        mag  = diff[COLOR_W] ? COLOR_W'(-diff) : diff[COLOR_W-1:0];
    end

    // One quotient bit per step: shift in, compare, subtract.
    always_comb begin
        shifted  = {acc_reg[ACC_W-2:0], 1'b0};
        rem_top  = shifted[ACC_W-1:PROD_W];
        acc_next = shifted;
        if (rem_top >= {1'b0, total}) begin
            acc_next = {rem_top - {1'b0, total}, shifted[PROD_W-1:1], 1'b1};
        end
    end

    // The load seeds the dividend with the product; each step advances the division.
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            acc_reg <= {{REM_W{1'b0}}, PROD_W'(mag) * PROD_W'(t_val)};
            neg_reg <= diff[COLOR_W];
        end else if (ctl.step) begin
            acc_reg <= acc_next;
        end
    end

    assign res.neg = neg_reg;
    assign res.mag = acc_reg[PROD_W-1:0];

endmodule

// ===== rtl/core/rfrg_merge.sv =====
// Merge stage: adds each lane quotient to its target, clamps and packs the result.
module rfrg_merge (
    input  rfrg_pkg::lane_res_t [rfrg_pkg::NUM_LANES-1:0] lane_res,
    input  rfrg_pkg::color_t    [rfrg_pkg::NUM_LANES-1:0] to_col,
    input  logic                                          fire,
    input  logic [rfrg_pkg::ID_W-1:0]                     notify_value,
    output rfrg_pkg::result_t                             result
);
    import rfrg_pkg::*;

    color_t [NUM_LANES-1:0] col;
    logic signed [SUM_W-1:0] q [NUM_LANES];
    logic signed [SUM_W-1:0] v [NUM_LANES];

    // Truncated signed quotient plus target, held to the color range.
    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            q[i] = signed'({2'b00, lane_res[i].mag});
            if (lane_res[i].neg) begin
                q[i] = -q[i];
            end
            v[i] = signed'(SUM_W'(to_col[i])) + q[i];
            if (v[i] < 0) begin
                col[i] = '0;
            end else if (v[i] > signed'(SUM_W'(COLOR_MAX))) begin
                col[i] = COLOR_W'(COLOR_MAX);
            end else begin
                col[i] = v[i][COLOR_W-1:0];
            end
        end
    end

    always_comb begin
        result.out_red     = col[0];
        result.out_green   = col[1];
        result.out_blue    = col[2];
        result.out_alpha   = col[3];
        result.hidden      = (col[3] == '0);
        result.notify_fire = fire;
        result.notify_out  = fire ? notify_value : '0;
    end

endmodule

// ===== rtl/core/rgba_fade_ramp_generator_core.sv =====
// A tick transfer passes in order through a multiply state, 24 divider steps and the merge into
// the output register, which it waits for when that is full; start and set transfers complete on acceptance.
// No new item is accepted while a tick is in the bit-serial dividers of the four lanes or awaits the output.
// A finished result waits in the output register while the next item is accepted.
// Reset (aresetn low, synchronous) sets the timer to the floor, the duration to one,
// clears all colors and the notification, and empties the output register.
`include "rgba_fade_ramp_generator_core_macros.svh"

module rgba_fade_ramp_generator_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // frame_skip, red, green, blue, alpha, duration, has_notify, notify_id, zero fill
    input  logic [rfrg_pkg::S_DATA_W-1:0]   s_tdata,
    // mode
    input  logic [rfrg_pkg::S_USER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_red, out_green, out_blue, out_alpha, hidden, notify_fire, notify_out, zero fill
    output logic [rfrg_pkg::M_DATA_W-1:0]   m_tdata
);
    import rfrg_pkg::*;

    state_t                  state_reg;
    logic [CNT_W-1:0]        step_cnt_reg;
    logic signed [TL_W-1:0]  time_left_reg;
    logic [TIME_BITS-1:0]    time_total_reg;
    logic [TIME_BITS-1:0]    t_reg;
    color_t [NUM_LANES-1:0]  start_reg;
    color_t [NUM_LANES-1:0]  target_reg;
    color_t [NUM_LANES-1:0]  current_reg;
    logic                    armed_reg;
    logic [ID_W-1:0]         notify_value_reg;
    logic                    fire_reg;
    logic                    m_tvalid_reg;
    result_t                 out_reg;

    in_data_t                in_d;
    mode_t                   mode;
    logic                    in_xfer;
    color_t [NUM_LANES-1:0]  in_col;
    logic [DUR_W-1:0]        dur_sat;
    logic [TIME_BITS-1:0]    dur_eff;
    logic signed [TL_W-1:0]  tl_dec;
    logic signed [TL_W-1:0]  tl_new;
    lane_ctl_t               lane_ctl;
    lane_res_t [NUM_LANES-1:0] lane_res;
    result_t                 merged;
    logic                    out_load;

    assign in_d    = in_data_t'(s_tdata[IN_W-1:0]);
    assign mode    = mode_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer = s_tvalid && s_tready;
    assign in_col  = {in_d.alpha, in_d.blue, in_d.green, in_d.red};

    // Duration saturates to the timer range, and zero counts as one.
    always_comb begin
        dur_sat = (32'(in_d.duration) > 32'(DUR_MAX)) ? DUR_W'(DUR_MAX) : in_d.duration;
        dur_eff = TIME_BITS'(dur_sat);
        if (dur_eff == '0) begin
            dur_eff = TIME_BITS'(1);
        end
    end

    // Timer count-down, held at the floor.
    always_comb begin
        tl_dec = time_left_reg - signed'(TL_W'(in_d.frame_skip)) - signed'(TL_W'(1));
        tl_new = (tl_dec < FLOOR_VAL) ? FLOOR_VAL : tl_dec;
    end

    assign lane_ctl.load = (state_reg == ST_MUL);
    assign lane_ctl.step = (state_reg == ST_DIV);
    assign out_load      = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    // One lane per color channel.
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        rfrg_lane u_lane (
            .aclk     (aclk),
            .ctl      (lane_ctl),
            .from_col (start_reg[g]),
            .to_col   (target_reg[g]),
            .t_val    (t_reg),
            .total    (time_total_reg),
            .res      (lane_res[g])
        );
    end

    rfrg_merge u_merge (
        .lane_res     (lane_res),
        .to_col       (target_reg),
        .fire         (fire_reg),
        .notify_value (notify_value_reg),
        .result       (merged)
    );

    // Sequencer and fade state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            step_cnt_reg     <= '0;
            time_left_reg    <= FLOOR_VAL;
            time_total_reg   <= TIME_BITS'(1);
            start_reg        <= '0;
            target_reg       <= '0;
            current_reg      <= '0;
            armed_reg        <= 1'b0;
            notify_value_reg <= '0;
            fire_reg         <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (in_xfer) begin
                        case (mode)
                            MODE_START: begin
                                start_reg        <= current_reg;
                                target_reg       <= in_col;
                                time_left_reg    <= signed'(TL_W'(dur_eff));
                                time_total_reg   <= dur_eff;
                                armed_reg        <= in_d.has_notify;
                                notify_value_reg <= in_d.notify_id;
                            end
                            MODE_SET: begin
                                current_reg <= in_col;
                            end
                            MODE_TICK: begin
                                time_left_reg <= tl_new;
                                t_reg         <= tl_new[TL_W-1] ? '0 : tl_new[TIME_BITS-1:0];
                                fire_reg      <= (tl_new == FLOOR_VAL) && armed_reg;
                                if (tl_new == FLOOR_VAL) begin
                                    armed_reg <= 1'b0;
                                end
                                state_reg <= ST_MUL;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_MUL: begin
                    step_cnt_reg <= '0;
                    state_reg    <= ST_DIV;
                end
                ST_DIV: begin
                    step_cnt_reg <= step_cnt_reg + CNT_W'(1);
                    if (step_cnt_reg == CNT_W'(PROD_W - 1)) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_load) begin
                        current_reg <= {merged.out_alpha, merged.out_blue,
                                        merged.out_green, merged.out_red};
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Output register between the sequencer and the result channel.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= merged;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_DATA_W - RES_W){1'b0}}, out_reg};

    // Checks on the timer, the divider sequence and the result contents.
    `RFRG_ASSERT_IMP(a_timer_floor, aclk, aresetn, 1'b1, time_left_reg >= FLOOR_VAL, "timer below floor")
    `RFRG_ASSERT_IMP(a_fire_at_floor, aclk, aresetn, out_load && fire_reg, time_left_reg == FLOOR_VAL, "notification outside floor")
    `RFRG_ASSERT_NXT(a_div_start, aclk, aresetn, state_reg == ST_MUL, (state_reg == ST_DIV) && (step_cnt_reg == '0), "divider did not start")
    `RFRG_ASSERT_IMP(a_hidden_flag, aclk, aresetn, m_tvalid_reg, out_reg.hidden == (out_reg.out_alpha == '0), "hidden flag mismatch")

endmodule
